[hdl/http_chunked_body_decoder_core_defines.svh]
// assertion macros for the chunked body decoder
// used by the top level only; expects i_clk and i_rst_n in scope
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// condition must hold at every clock edge out of reset
`define HCBD_ASSERT_ALWAYS(name, cond) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("hcbd check failed");

// antecedent at one edge implies consequent at the next edge
`define HCBD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hcbd check failed");

`else

`define HCBD_ASSERT_ALWAYS(name, cond)
`define HCBD_ASSERT_NEXT(name, ante, cons)

`endif

`endif

[hdl/hcbd_pkg.sv]
// shared types, constants and helper functions of the chunked body decoder
// no dependencies
package hcbd_pkg;

    localparam int COUNT_BITS = 32;
    localparam int HEX_BITS   = 4;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_FF   = 8'h0C;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;
    localparam logic [7:0] CH_LX   = 8'h78;
    localparam logic [7:0] CH_UX   = 8'h58;

    localparam logic [1:0] SKIP_BYTES = 2'd2;

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef enum logic [2:0] {
        PH_LINE    = 3'd0,
        PH_LINE_CR = 3'd1,
        PH_DATA    = 3'd2,
        PH_SKIP    = 3'd3,
        PH_DONE    = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        PFX_BLANK   = 2'd0,
        PFX_ZERO    = 2'd1,
        PFX_DIGITS  = 2'd2,
        PFX_AFTER_X = 2'd3
    } t_prefix;

    typedef struct packed {
        logic       hit;
        logic [7:0] data;
        logic       body_end;
    } t_result;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

    // returns {valid, nibble}
    function automatic logic [HEX_BITS:0] hex_decode(input logic [7:0] c);
        logic [HEX_BITS:0] r;
        r = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, HEX_BITS'(c - CH_ZERO)};
        end else if (c >= CH_LA && c <= CH_LF_HEX) begin
            r = {1'b1, HEX_BITS'(c - CH_LA + 8'd10)};
        end else if (c >= CH_UA && c <= CH_UF) begin
            r = {1'b1, HEX_BITS'(c - CH_UA + 8'd10)};
        end
        return r;
    endfunction

endpackage

[hdl/hcbd_in_if.sv]
// input channel of the chunked body decoder: one raw body word per handshake
// depends on nothing
interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

[hdl/hcbd_out_if.sv]
// result channel of the chunked body decoder: payload word or end marker
// depends on nothing
interface hcbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       body_end;

    modport source (output valid, output out_byte, output body_end, input ready);
    modport sink   (input valid, input out_byte, input body_end, output ready);
endinterface

[hdl/hcbd_size_parse.sv]
// hex size line parser: next count, prefix tracking and close flag for one word
// depends on hcbd_pkg
module hcbd_size_parse
    import hcbd_pkg::*;
(
    input  logic [7:0] i_byte,
    input  logic       i_cr_first,
    input  logic       i_byte_en,
    input  t_count     i_count,
    input  t_prefix    i_prefix,
    input  logic       i_closed,
    output t_count     o_count,
    output t_prefix    o_prefix,
    output logic       o_closed
);

    logic [HEX_BITS:0] hx;
    logic              closed_pre;
    logic              add;
    logic              sat;

    assign hx  = hex_decode(i_byte);
    assign sat = |i_count[COUNT_BITS-1 -: HEX_BITS];

    always_comb begin
        // a held-back cr counts as a blank before digits, else it closes them
        closed_pre = i_closed | (i_cr_first & (i_prefix != PFX_BLANK));
        o_prefix   = i_prefix;
        o_closed   = closed_pre;
        add        = 1'b0;
        if (i_byte_en && !closed_pre) begin
            case (i_prefix)
                PFX_BLANK: begin
                    if (!is_blank(i_byte)) begin
                        if (!hx[HEX_BITS]) begin
                            o_closed = 1'b1;
                        end else begin
                            add      = 1'b1;
                            o_prefix = (i_byte == CH_ZERO) ? PFX_ZERO : PFX_DIGITS;
                        end
                    end
                end
                PFX_ZERO: begin
                    if (i_byte == CH_LX || i_byte == CH_UX) begin
                        o_prefix = PFX_AFTER_X;
                    end else if (!hx[HEX_BITS]) begin
                        o_closed = 1'b1;
                    end else begin
                        add      = 1'b1;
                        o_prefix = PFX_DIGITS;
                    end
                end
                default: begin
                    if (!hx[HEX_BITS]) begin
                        o_closed = 1'b1;
                    end else begin
                        add      = 1'b1;
                        o_prefix = PFX_DIGITS;
                    end
                end
            endcase
        end
    end

    // saturate once a nibble would shift out of the top
    always_comb begin
        o_count = i_count;
        if (add) begin
            o_count = sat ? '1 : {i_count[COUNT_BITS-HEX_BITS-1:0], hx[HEX_BITS-1:0]};
        end
    end

endmodule

[hdl/hcbd_decoder_fsm.sv]
// phase state machine of the chunked decoder: size line, data, trailing crlf, done
// depends on hcbd_pkg and hcbd_size_parse
module hcbd_decoder_fsm
    import hcbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_result    o_res
);

    t_phase     r_phase,  n_phase;
    t_count     r_count,  n_count;
    logic       r_closed, n_closed;
    t_prefix    r_prefix, n_prefix;
    logic [1:0] r_skip,   n_skip;

    t_count     p_count;
    t_prefix    p_prefix;
    logic       p_closed;
    t_count     cnt_dec;
    logic [1:0] skip_dec;

    hcbd_size_parse u_parse (
        .i_byte     (i_byte),
        .i_cr_first (r_phase == PH_LINE_CR),
        .i_byte_en  ((r_phase == PH_LINE) || (i_byte != CH_CR)),
        .i_count    (r_count),
        .i_prefix   (r_prefix),
        .i_closed   (r_closed),
        .o_count    (p_count),
        .o_prefix   (p_prefix),
        .o_closed   (p_closed)
    );

    assign cnt_dec  = r_count - {{(COUNT_BITS-1){1'b0}}, |r_count};
    assign skip_dec = r_skip - {1'b0, |r_skip};

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_closed = r_closed;
        n_prefix = r_prefix;
        n_skip   = r_skip;
        unique case (r_phase)
            PH_LINE: begin
                if (i_byte == CH_CR) begin
                    n_phase = PH_LINE_CR;
                end else begin
                    n_count  = p_count;
                    n_prefix = p_prefix;
                    n_closed = p_closed;
                end
            end
            PH_LINE_CR: begin
                if (i_byte == CH_LF) begin
                    n_phase = (r_count == '0) ? PH_DONE : PH_DATA;
                end else begin
                    n_count  = p_count;
                    n_prefix = p_prefix;
                    n_closed = p_closed;
                    n_phase  = (i_byte == CH_CR) ? PH_LINE_CR : PH_LINE;
                end
            end
            PH_DATA: begin
                n_count = cnt_dec;
                if (cnt_dec == '0) begin
                    n_phase = PH_SKIP;
                    n_skip  = SKIP_BYTES;
                end
            end
            PH_SKIP: begin
                if (skip_dec == 2'd0) begin
                    n_phase  = PH_LINE;
                    n_count  = '0;
                    n_closed = 1'b0;
                    n_prefix = PFX_BLANK;
                    n_skip   = 2'd0;
                end else begin
                    n_skip = skip_dec;
                end
            end
            default: ;
        endcase
    end

    // result for the current word
    always_comb begin
        o_res = '0;
        unique case (r_phase)
            PH_LINE_CR: begin
                if (i_byte == CH_LF && r_count == '0) begin
                    o_res.hit      = 1'b1;
                    o_res.body_end = 1'b1;
                end
            end
            PH_DATA: begin
                o_res.hit  = 1'b1;
                o_res.data = i_byte;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LINE;
            r_count  <= '0;
            r_closed <= 1'b0;
            r_prefix <= PFX_BLANK;
            r_skip   <= 2'd0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_closed <= n_closed;
            r_prefix <= n_prefix;
            r_skip   <= n_skip;
        end
    end

endmodule

[hdl/http_chunked_body_decoder_core.sv]
// chunked body decoder, top level: input register, phase machine, result register
// depends on hcbd_pkg, hcbd_in_if, hcbd_out_if, hcbd_decoder_fsm and the defines header
//
// usage
//   i_in carries the raw chunked body, one word per valid/ready handshake.
//   o_out carries payload words (body_end low) and, once, an end marker
//   (body_end high, out_byte zero) when the zero-size line's crlf arrives.
//   size lines, the crlf after each chunk and anything after the end
//   produce no result.
// timing
//   a word taken into the input register is decoded from there into the result
//   register, which drives o_out.
//   one word per cycle is sustained while o_out does not stall; the decode of a word is a single pass
//   through the phase machine and the hex size parser between the two registers.
// reset
//   i_rst_n low (synchronous) empties both registers and returns the parser
//   to the start of a size line with a zero count.
// stall
//   while o_out.ready is low and a result is held, the input register keeps
//   its word and i_in.ready drops once that register is full; nothing is lost.
`include "http_chunked_body_decoder_core_defines.svh"

module http_chunked_body_decoder_core
    import hcbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    hcbd_in_if.sink     i_in,
    hcbd_out_if.source  o_out
);

    // input register
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;

    // result register
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_data;
    logic       r_out_end;

    logic       in_fire;
    logic       step_go;
    t_result    res;

    // decode the held word when the result slot is free or draining
    assign step_go = r_in_valid && (!r_out_valid || o_out.ready);

    assign i_in.ready = !r_in_valid || step_go;
    assign in_fire    = i_in.valid && i_in.ready;

    hcbd_decoder_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step_go),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    assign n_in_valid  = in_fire || (r_in_valid && !step_go);
    assign n_out_valid = (r_out_valid && !o_out.ready) || (step_go && res.hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_in.in_byte;
        end
        if (step_go && res.hit) begin
            r_out_data <= res.data;
            r_out_end  <= res.body_end;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_data;
    assign o_out.body_end = r_out_end;

    // the end marker never carries payload
    `HCBD_ASSERT_ALWAYS(a_end_zero, !(r_out_valid && r_out_end) || (r_out_data == 8'd0))

    // nothing follows the end marker out of the decoder
    `HCBD_ASSERT_NEXT(a_end_last, step_go && res.hit && res.body_end, !(step_go && res.hit))

    // a held word plus a stalled result must block the input side
    `HCBD_ASSERT_ALWAYS(a_stall_blocks, !(r_in_valid && r_out_valid && !o_out.ready) || !i_in.ready)

endmodule
